FILE: hw/rtl/dset_pkg.sv
`default_nettype none

package dset_pkg;

  // Default number of slots in the table
  localparam int unsigned DefTableSlots = 64;

  // A list command emits at most this many entries
  localparam int unsigned MaxResults = 64;

  // Field widths fixed by the command format
  localparam int unsigned IdW     = 6;
  localparam int unsigned LayerW  = 8;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned ActiveW = 7;

  typedef enum logic [1:0] {
    ModeAdd  = 2'd0,
    ModeDel  = 2'd1,
    ModeSet  = 2'd2,
    ModeList = 2'd3
  } mode_e;

  // One table slot as stored in memory
  typedef struct packed {
    logic                    occ;
    logic [IdW-1:0]          ent;
    logic [LayerW-1:0]       lay;
    logic signed [KeyW-1:0]  key;
  } slot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dset_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module dset_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/depth_sorted_entity_table_core.sv
`default_nettype none

// Depth-sorted entity table. Commands are taken when start is high and busy is low;
// busy stays high until the last result beat of that command has been shown. Results
// appear for exactly one cycle each on result_valid_o and cannot be held off, so the
// receiver must take every beat. All slots live in one RAM with a registered read port,
// and add, delete and list visit the slots one per cycle, up to n of them, where n is
// the active slot count (saturated to TableSlots). A set that finds its id then runs a
// stable insertion sort over the active slots in the same RAM, at most one compare per
// cycle, moving up to n*(n-1)/2 slots for a reversed table. After reset the table is
// swept to zero with busy high; the configuration channel is always ready, also during
// that sweep. A list emits at most 64 entries, the final one flagged with last_o.
module depth_sorted_entity_table_core #(
  parameter int unsigned TableSlots = dset_pkg::DefTableSlots
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dset_pkg::ActiveW-1:0]    cfg_data_i,
  // Command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [dset_pkg::IdW-1:0]        entity_id_i,
  input  wire logic [dset_pkg::LayerW-1:0]     layer_i,
  input  wire logic signed [dset_pkg::KeyW-1:0] depth_key_i,
  // Result beats
  output logic                                 result_valid_o,
  output logic [dset_pkg::IdW-1:0]             result_id_o,
  output logic                                 found_o,
  output logic                                 last_o
);

  import dset_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableSlots);
  localparam int unsigned CntW  = $clog2(TableSlots + 1);
  localparam int unsigned LcntW = $clog2(MaxResults + 1);
  localparam int unsigned SlotW = $bits(slot_t);

  // Sequencer states
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SSrd   = 3'd3;
  localparam logic [2:0] SSld   = 3'd4;
  localparam logic [2:0] SScmp  = 3'd5;
  localparam logic [2:0] SSput  = 3'd6;
  localparam logic [2:0] SDone  = 3'd7;

  // Control registers
  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    issue_q, issue_d;
  logic               rv_q, rv_d;
  logic               ov_q, ov_d;
  logic [ActiveW-1:0] active_q;
  logic               pend_v_q, pend_v_d;
  logic [LcntW-1:0]   lcnt_q, lcnt_d;

  // Payload registers
  mode_e              mode_q, mode_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [LayerW-1:0]  layer_q, layer_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               hit_q, hit_d;
  logic [IdxW-1:0]    rslot_q, rslot_d;
  logic [IdW-1:0]     pend_id_q, pend_id_d;
  logic [IdxW-1:0]    i_q, i_d;
  logic [IdxW-1:0]    j_q, j_d;
  slot_t              t_q, t_d;
  logic [IdW-1:0]     oid_q, oid_d;
  logic               ofound_q, ofound_d;
  logic               olast_q, olast_d;

  // RAM port signals
  logic               we;
  logic [IdxW-1:0]    waddr;
  slot_t              wdata;
  logic [IdxW-1:0]    raddr;
  logic [SlotW-1:0]   rdata;
  slot_t              rd;
  logic [CntW-1:0]    i_nx;
  logic               accept;
  logic               id_hit;

  assign rd     = slot_t'(rdata);
  assign i_nx   = CntW'(i_q) + CntW'(1);
  assign accept = start && !busy;
  assign id_hit = rd.occ && (rd.ent == id_q);

  dset_ram #(
    .Width(SlotW),
    .Depth(TableSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(SlotW'(wdata)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    issue_d   = issue_q;
    rv_d      = 1'b0;
    ov_d      = 1'b0;
    pend_v_d  = pend_v_q;
    lcnt_d    = lcnt_q;
    mode_d    = mode_q;
    id_d      = id_q;
    layer_d   = layer_q;
    key_d     = key_q;
    n_d       = n_q;
    hit_d     = hit_q;
    rslot_d   = rslot_q;
    pend_id_d = pend_id_q;
    i_d       = i_q;
    j_d       = j_q;
    t_d       = t_q;
    oid_d     = oid_q;
    ofound_d  = ofound_q;
    olast_d   = olast_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;

    unique case (state_q)
      // Zero the table after reset, one slot a cycle
      SClear: begin
        we      = 1'b1;
        waddr   = issue_q[IdxW-1:0];
        issue_d = issue_q + CntW'(1);
        if (issue_q == CntW'(TableSlots - 1)) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (accept) begin
          mode_d   = mode_e'(mode_i);
          id_d     = entity_id_i;
          layer_d  = layer_i;
          key_d    = depth_key_i;
          n_d      = (32'(active_q) > 32'(TableSlots)) ? CntW'(TableSlots) : CntW'(active_q);
          issue_d  = '0;
          hit_d    = 1'b0;
          pend_v_d = 1'b0;
          lcnt_d   = '0;
          state_d  = SScan;
        end
      end

      // Linear scan: issue one read a cycle, judge the slot read last cycle
      SScan: begin
        if (issue_q < n_q) begin
          raddr   = issue_q[IdxW-1:0];
          issue_d = issue_q + CntW'(1);
          rv_d    = 1'b1;
          rslot_d = issue_q[IdxW-1:0];
        end
        if (rv_q) begin
          unique case (mode_q)
            ModeAdd: begin
              if (!rd.occ) begin
                we        = 1'b1;
                waddr     = rslot_q;
                wdata     = rd;
                wdata.occ = 1'b1;
                wdata.ent = id_q;
                hit_d     = 1'b1;
                state_d   = SDone;
              end
            end
            ModeDel: begin
              if (id_hit) begin
                we        = 1'b1;
                waddr     = rslot_q;
                wdata     = rd;
                wdata.occ = 1'b0;
                hit_d     = 1'b1;
                state_d   = SDone;
              end
            end
            ModeSet: begin
              if (id_hit) begin
                we        = 1'b1;
                waddr     = rslot_q;
                wdata     = rd;
                wdata.lay = layer_q;
                wdata.key = key_q;
                hit_d     = 1'b1;
                i_d       = IdxW'(1);
                state_d   = (n_q >= CntW'(2)) ? SSrd : SDone;
              end
            end
            ModeList: begin
              if (rd.occ && (rd.lay == layer_q)) begin
                // Hold one match back so the final beat can carry last
                if (pend_v_q) begin
                  ov_d     = 1'b1;
                  oid_d    = pend_id_q;
                  ofound_d = 1'b1;
                  olast_d  = 1'b0;
                end
                pend_v_d  = 1'b1;
                pend_id_d = rd.ent;
                lcnt_d    = lcnt_q + LcntW'(1);
                if (lcnt_q == LcntW'(MaxResults - 1)) begin
                  state_d = SDone;
                end
              end
            end
            default: ;
          endcase
        end else if (issue_q == n_q) begin
          state_d = SDone;
        end
      end

      // Insertion sort: fetch element i
      SSrd: begin
        raddr   = i_q;
        state_d = SSld;
      end

      SSld: begin
        t_d     = rd;
        j_d     = i_q;
        raddr   = i_q - IdxW'(1);
        state_d = SScmp;
      end

      // Compare held element against slot j-1, shift it up if larger
      SScmp: begin
        we    = 1'b1;
        waddr = j_q;
        if ($signed(t_q.key) < $signed(rd.key)) begin
          wdata = rd;
          j_d   = j_q - IdxW'(1);
          if (j_q == IdxW'(1)) begin
            state_d = SSput;
          end else begin
            raddr = j_q - IdxW'(2);
          end
        end else begin
          wdata = t_q;
          if (i_nx == n_q) begin
            state_d = SDone;
          end else begin
            i_d     = i_q + IdxW'(1);
            raddr   = i_q + IdxW'(1);
            state_d = SSld;
          end
        end
      end

      // Held element lands in slot 0
      SSput: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = t_q;
        if (i_nx == n_q) begin
          state_d = SDone;
        end else begin
          i_d     = i_q + IdxW'(1);
          raddr   = i_q + IdxW'(1);
          state_d = SSld;
        end
      end

      // Final beat of the command
      SDone: begin
        ov_d    = 1'b1;
        olast_d = 1'b1;
        if (mode_q == ModeList) begin
          oid_d    = pend_v_q ? pend_id_q : '0;
          ofound_d = pend_v_q;
        end else begin
          oid_d    = id_q;
          ofound_d = hit_q;
        end
        state_d = SIdle;
      end

      default: state_d = SIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      issue_q  <= '0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
      pend_v_q <= 1'b0;
      lcnt_q   <= '0;
      active_q <= '0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rv_q     <= rv_d;
      ov_q     <= ov_d;
      pend_v_q <= pend_v_d;
      lcnt_q   <= lcnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    id_q      <= id_d;
    layer_q   <= layer_d;
    key_q     <= key_d;
    n_q       <= n_d;
    hit_q     <= hit_d;
    rslot_q   <= rslot_d;
    pend_id_q <= pend_id_d;
    i_q       <= i_d;
    j_q       <= j_d;
    t_q       <= t_d;
    oid_q     <= oid_d;
    ofound_q  <= ofound_d;
    olast_q   <= olast_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != SIdle) || ov_q;
  assign result_valid_o = ov_q;
  assign result_id_o    = oid_q;
  assign found_o        = ofound_q;
  assign last_o         = olast_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dset_chk.sv
`default_nettype none

// Port-level checks for the entity table
module dset_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic found_o,
  input wire logic last_o
);

  // A result beat only belongs to a command in flight
  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result beat while not busy");

  // A beat without a hit always closes the command
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> last_o)
    else $error("not-found beat without last");

  // An accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Nothing follows the final beat directly
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("beat right after last");

endmodule

bind depth_sorted_entity_table_core dset_chk u_dset_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .found_o       (found_o),
  .last_o        (last_o)
);

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dset_pkg::*;

  localparam int unsigned TableSlots = DefTableSlots;
  // Cycles without any beat, slot count write or accepted command before the run is declared hung
  localparam int unsigned IdleLimit  = 20000;

  // One result beat: listed or echoed id, found flag, last flag
  typedef struct packed {
    logic [IdW-1:0] id;
    logic           found;
    logic           last;
  } entity_beat_t;

  // One step of the directed part: either a slot count write or a command
  typedef struct {
    bit                     set_active;
    logic [ActiveW-1:0]     active;
    mode_e                  op;
    logic [IdW-1:0]         id;
    logic [LayerW-1:0]      layer;
    logic signed [KeyW-1:0] key;
    bit                     has_exp;
    entity_beat_t           want;
  } step_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [ActiveW-1:0]     cfg_data_i  = '0;
  logic                   start       = 1'b0;
  logic                   busy;
  mode_e                  mode_i      = ModeAdd;
  logic [IdW-1:0]         entity_id_i = '0;
  logic [LayerW-1:0]      layer_i     = '0;
  logic signed [KeyW-1:0] depth_key_i = '0;
  logic                   result_valid_o;
  logic [IdW-1:0]         result_id_o;
  logic                   found_o;
  logic                   last_o;

  // Shadow copy of the table and the slot count register
  slot_t              model_slot [TableSlots];
  logic [ActiveW-1:0] model_active;
  entity_beat_t       expected_beats [$];

  // Fixed expectation handed over by the directed table for the next command
  bit           exp_from_row = 1'b0;
  entity_beat_t row_exp      = '0;

  int unsigned idle_pct      = 0;
  int unsigned errors        = 0;
  int unsigned beats_checked = 0;
  int unsigned idle_cycles   = 0;
  int unsigned longest_list  = 0;
  int unsigned op_count [4]  = '{0, 0, 0, 0};

  depth_sorted_entity_table_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .entity_id_i    (entity_id_i),
    .layer_i        (layer_i),
    .depth_key_i    (depth_key_i),
    .result_valid_o (result_valid_o),
    .result_id_o    (result_id_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Slot count as the block sees it, saturated to the table size
  function automatic int unsigned slots_in_use();
    return (model_active > TableSlots) ? TableSlots : int'(model_active);
  endfunction

  // First occupied active slot, optionally only one with a nonzero layer
  function automatic int first_live_slot(input bit stray_layer_only);
    for (int i = 0; i < int'(slots_in_use()); i++) begin
      if (model_slot[i].occ && (!stray_layer_only || model_slot[i].lay != '0)) return i;
    end
    return -1;
  endfunction

  // Update the shadow table for one command and queue the beats it must produce
  task automatic apply_table_command(input mode_e op, input logic [IdW-1:0] id,
                                     input logic [LayerW-1:0] layer,
                                     input logic signed [KeyW-1:0] key);
    int unsigned  n;
    int unsigned  hit_at;
    bit           match;
    slot_t        moving;
    entity_beat_t beat;
    entity_beat_t listed [$];
    n      = slots_in_use();
    hit_at = n;
    if (op == ModeList) begin
      for (int unsigned i = 0; i < n && listed.size() < MaxResults; i++) begin
        if (model_slot[i].occ && model_slot[i].lay == layer) begin
          beat = '{id: model_slot[i].ent, found: 1'b1, last: 1'b0};
          listed.push_back(beat);
        end
      end
      // nothing matched: a single empty beat
      if (listed.size() == 0) begin
        listed.push_back('{id: '0, found: 1'b0, last: 1'b1});
      end else begin
        listed[listed.size()-1].last = 1'b1;
        if (listed.size() > longest_list) longest_list = listed.size();
      end
    end else begin
      for (int unsigned i = 0; i < n && hit_at == n; i++) begin
        if (op == ModeAdd) match = !model_slot[i].occ;
        else match = model_slot[i].occ && model_slot[i].ent == id;
        if (match) hit_at = i;
      end
      if (hit_at < n) begin
        case (op)
          ModeAdd: begin
            model_slot[hit_at].occ = 1'b1;
            model_slot[hit_at].ent = id;
          end
          ModeDel: model_slot[hit_at].occ = 1'b0;
          ModeSet: begin
            model_slot[hit_at].lay = layer;
            model_slot[hit_at].key = key;
            // stable insertion sort over all active slots, free ones too
            for (int unsigned i = 1; i < n; i++) begin
              for (int unsigned j = i;
                   j > 0 && $signed(model_slot[j].key) < $signed(model_slot[j-1].key);
                   j--) begin
                moving           = model_slot[j];
                model_slot[j]    = model_slot[j-1];
                model_slot[j-1]  = moving;
              end
            end
          end
          default: ;
        endcase
      end
      listed.push_back('{id: id, found: hit_at < n, last: 1'b1});
    end
    if (exp_from_row) expected_beats.push_back(row_exp);
    else foreach (listed[k]) expected_beats.push_back(listed[k]);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Result checking, command and register tracking, hang watchdog
  always @(posedge clk_i) begin
    bit           moved;
    entity_beat_t want;
    moved = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        moved = 1'b1;
        beats_checked++;
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: beat with nothing expected, got id %0d found %0b last %0b",
                   $time, result_id_o, found_o, last_o);
        end else begin
          want = expected_beats.pop_front();
          check_field("result_id", 8'(want.id), 8'(result_id_o));
          check_field("found", 8'(want.found), 8'(found_o));
          check_field("last", 8'(want.last), 8'(last_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved        = 1'b1;
        model_active = cfg_data_i;
      end
      if (start && !busy) begin
        moved = 1'b1;
        op_count[mode_i]++;
        apply_table_command(mode_i, entity_id_i, layer_i, depth_key_i);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles, %0d still expected", $time, IdleLimit,
                 expected_beats.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Drop start and hold off until the block is idle with nothing outstanding
  task automatic wait_drained();
    start = 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Slot count write, only from an idle block
  task automatic write_active(input logic [ActiveW-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Present one command after a random gap; returns at the falling edge after acceptance
  task automatic issue(input mode_e op, input logic [IdW-1:0] id,
                       input logic [LayerW-1:0] layer, input logic signed [KeyW-1:0] key,
                       input bit has_exp, input entity_beat_t want);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i       = op;
    entity_id_i  = id;
    layer_i      = layer;
    depth_key_i  = key;
    exp_from_row = has_exp;
    row_exp      = want;
    start        = 1'b1;
    do @(posedge clk_i); while (!(start && !busy));
    @(negedge clk_i);
  endtask

  // Random command, mostly aimed at ids and layers that live in the table
  task automatic random_command();
    int unsigned            pick;
    mode_e                  op;
    logic [IdW-1:0]         id;
    logic [LayerW-1:0]      layer;
    logic signed [KeyW-1:0] key;
    int unsigned            live [$];
    if ($urandom_range(15) == 0) wait_drained();
    for (int unsigned i = 0; i < slots_in_use(); i++) begin
      if (model_slot[i].occ) live.push_back(i);
    end
    pick  = $urandom_range(99);
    op    = (pick < 30) ? ModeAdd : (pick < 45) ? ModeDel : (pick < 75) ? ModeSet : ModeList;
    id    = ($urandom_range(3) == 0) ? IdW'($urandom_range(63)) : IdW'($urandom_range(7));
    layer = ($urandom_range(4) == 0) ? LayerW'($urandom) : LayerW'($urandom_range(2));
    // small keys give ties, which exercise sort stability
    key   = $urandom_range(1) ? KeyW'($urandom_range(3)) : KeyW'($urandom);
    if (live.size() != 0 && $urandom_range(9) < 7) begin
      pick = live[$urandom_range(live.size() - 1)];
      id   = model_slot[pick].ent;
      if (op == ModeList) layer = model_slot[pick].lay;
    end
    issue(op, id, layer, key, 1'b0, '0);
  endtask

  function automatic step_row_t cmd_row(input mode_e op, input logic [IdW-1:0] id,
                                        input logic [LayerW-1:0] layer,
                                        input logic signed [KeyW-1:0] key,
                                        input bit has_exp = 1'b0,
                                        input logic exp_found = 1'b0);
    step_row_t r;
    r = '{set_active: 1'b0, active: '0, op: op, id: id, layer: layer, key: key,
          has_exp: has_exp, want: '0};
    r.want = '{id: (op == ModeList) ? '0 : id, found: exp_found, last: 1'b1};
    return r;
  endfunction

  function automatic step_row_t active_row(input logic [ActiveW-1:0] value);
    step_row_t r;
    r = '{set_active: 1'b1, active: value, op: ModeAdd, id: '0, layer: '0, key: '0,
          has_exp: 1'b0, want: '0};
    return r;
  endfunction

  initial begin
    step_row_t   directed_rows [$];
    step_row_t   r;
    int unsigned order [TableSlots];
    int unsigned swap_at;
    int unsigned held;

    foreach (model_slot[i]) model_slot[i] = '0;
    model_active = '0;

    // Empty register: nothing is active, so nothing is found
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd0, 16'h0000, 1'b1, 1'b0));
    directed_rows.push_back(cmd_row(ModeAdd, 6'd63, 8'd0, 16'h0000, 1'b1, 1'b0));
    directed_rows.push_back(cmd_row(ModeSet, 6'd0, 8'd255, 16'h8000, 1'b1, 1'b0));
    directed_rows.push_back(cmd_row(ModeDel, 6'd0, 8'd0, 16'h0000, 1'b1, 1'b0));
    // Count above table size saturates
    directed_rows.push_back(active_row(7'd127));
    directed_rows.push_back(cmd_row(ModeAdd, 6'd63, 8'd0, 16'h0000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeAdd, 6'd0, 8'd0, 16'h0000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeAdd, 6'd42, 8'd0, 16'h0000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd0, 16'h0000));
    // Key extremes move entries to both ends past the free slots
    directed_rows.push_back(cmd_row(ModeSet, 6'd63, 8'd255, 16'h7fff, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeSet, 6'd0, 8'd255, 16'h8000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeSet, 6'd42, 8'd255, 16'hffff, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd255, 16'h0000));
    directed_rows.push_back(cmd_row(ModeSet, 6'd5, 8'd9, 16'h0064, 1'b1, 1'b0));
    // Freed slot no longer matches its id
    directed_rows.push_back(cmd_row(ModeDel, 6'd42, 8'd0, 16'h0000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeDel, 6'd42, 8'd0, 16'h0000, 1'b1, 1'b0));
    directed_rows.push_back(cmd_row(ModeSet, 6'd42, 8'd1, 16'h0001, 1'b1, 1'b0));
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd7, 16'h0000, 1'b1, 1'b0));
    // Duplicate id lands in the freed slot, which kept its layer
    directed_rows.push_back(cmd_row(ModeAdd, 6'd0, 8'd0, 16'h0000, 1'b1, 1'b1));
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd255, 16'h0000));
    directed_rows.push_back(cmd_row(ModeSet, 6'd0, 8'd1, 16'h0015, 1'b1, 1'b1));
    // Shrinking the count hides slots without clearing them
    directed_rows.push_back(active_row(7'd1));
    directed_rows.push_back(cmd_row(ModeList, 6'd0, 8'd255, 16'h0000));
    directed_rows.push_back(cmd_row(ModeAdd, 6'd21, 8'd0, 16'h0000));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      if (r.set_active) write_active(r.active);
      else issue(r.op, r.id, r.layer, r.key, r.has_exp, r.want);
    end

    // Small tables, back to back and then with sparse commands
    write_active(7'd6);
    idle_pct = 0;
    repeat (10) random_command();
    write_active(7'd13);
    idle_pct = 62;
    repeat (10) random_command();

    // Full table: empty it, fill every slot, move all entries to layer 0, list them
    write_active(7'd64);
    idle_pct = 29;
    for (int s = first_live_slot(1'b0); s >= 0; s = first_live_slot(1'b0)) begin
      issue(ModeDel, model_slot[s].ent, '0, '0, 1'b0, '0);
    end
    foreach (order[i]) order[i] = i;
    for (int i = TableSlots - 1; i > 0; i--) begin
      swap_at        = $urandom_range(i);
      held           = order[i];
      order[i]       = order[swap_at];
      order[swap_at] = held;
    end
    foreach (order[i]) issue(ModeAdd, IdW'(order[i]), LayerW'($urandom), KeyW'($urandom),
                             1'b0, '0);
    for (int s = first_live_slot(1'b1); s >= 0; s = first_live_slot(1'b1)) begin
      issue(ModeSet, model_slot[s].ent, '0, KeyW'($urandom), 1'b0, '0);
    end
    issue(ModeList, '0, '0, '0, 1'b0, '0);
    repeat (6) random_command();

    write_active(7'd3);
    idle_pct = 62;
    repeat (12) random_command();

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("tb: %0d commands (%0d add, %0d delete, %0d set, %0d list), %0d beats checked",
             op_count[ModeAdd] + op_count[ModeDel] + op_count[ModeSet] + op_count[ModeList],
             op_count[ModeAdd], op_count[ModeDel], op_count[ModeSet], op_count[ModeList],
             beats_checked);
    $display("tb: slot counts 0, 1, 3, 6, 13, 64 and saturated 127; longest list %0d",
             longest_list);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
